@@ design/char_lcd_command_sequencer_assert.svh @@
// Assertion macros for the character-LCD command sequencer.
// Used by the port checker; no other dependencies.
`ifndef CHAR_LCD_COMMAND_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_COMMAND_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CLCD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clcd: assertion failed");

// Next-cycle implication, disabled during reset.
`define CLCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clcd: assertion failed");

`endif

@@ design/clcd_pkg.sv @@
// Shared types, command bytes and the microcode ROM of the LCD command sequencer.
// No dependencies.
package clcd_pkg;

   localparam int MaxResults     = 40;
   localparam int DefLineColumns = 16;
   localparam int DefMaxShift    = 40;
   localparam int PatternRows    = 8;
   localparam int CntWidth       = $clog2(MaxResults + 1);
   localparam int PcWidth        = 4;

   typedef logic [CntWidth-1:0] cnt_type;
   typedef logic [PcWidth-1:0]  pc_type;

   // request kinds
   localparam logic [2:0] KIND_INIT    = 3'd0;
   localparam logic [2:0] KIND_CHAR    = 3'd1;
   localparam logic [2:0] KIND_CURSOR  = 3'd2;
   localparam logic [2:0] KIND_CLEAR   = 3'd3;
   localparam logic [2:0] KIND_DSHIFT  = 3'd4;
   localparam logic [2:0] KIND_CSHIFT  = 3'd5;
   localparam logic [2:0] KIND_PATTERN = 3'd6;

   // configuration register indexes
   localparam logic [1:0] CSR_FONT      = 2'd0;
   localparam logic [1:0] CSR_TWO_LINES = 2'd1;
   localparam logic [1:0] CSR_BUS_8BIT  = 2'd2;
   localparam logic [1:0] CSR_INCREMENT = 2'd3;

   // command bytes
   localparam logic [7:0] CMD_FUNCTION_SET  = 8'h20;
   localparam logic [7:0] CMD_CLEAR         = 8'h01;
   localparam logic [7:0] CMD_DISPLAY_ON    = 8'h0C;
   localparam logic [7:0] CMD_ENTRY_MODE    = 8'h04;
   localparam logic [7:0] CMD_DDRAM         = 8'h80;
   localparam logic [7:0] CMD_DISPLAY_SHIFT = 8'h18;
   localparam logic [7:0] CMD_CURSOR_SHIFT  = 8'h10;
   localparam logic [7:0] CMD_CGRAM         = 8'h40;
   localparam logic [7:0] LINE2_BASE        = 8'h40;
   localparam logic [7:0] CHAR_SPACE        = 8'h20;

   localparam logic [4:0] WAIT_INIT_MS = 5'd30;
   localparam logic [1:0] WAIT_CMD_MS  = 2'd2;

   // byte source of one bus write
   typedef enum logic [3:0] {
      SEL_FSET,
      SEL_DISP_ON,
      SEL_CLEAR,
      SEL_ENTRY,
      SEL_HOME,
      SEL_LINE2,
      SEL_SPACE,
      SEL_CHAR,
      SEL_CURSOR,
      SEL_DSHIFT,
      SEL_CSHIFT,
      SEL_CGRAM,
      SEL_ROW
   } sel_type;

   // one microcode word: a single bus write
   typedef struct packed {
      logic    rs;       // register select of the write
      sel_type sel;
      logic    wb30;     // init power-up wait before
      logic    wa2;      // 2 ms wait after, on the final iteration only
      logic    rep;      // repeat while the loop counter is above one
      logic    ld_cols;  // load the loop counter with the line width, capped at 18
      logic    fin;      // last step of the program
   } ucode_type;

   typedef struct packed {
      logic font;
      logic two_lines;
      logic bus_8bit;
      logic increment;
   } cfg_type;

   typedef struct packed {
      logic      fire;
      ucode_type uc;
      logic      final_iter;
   } issue_type;

   // program entry points
   localparam pc_type PC_INIT    = 4'd0;
   localparam pc_type PC_CHAR    = 4'd4;
   localparam pc_type PC_CURSOR  = 4'd5;
   localparam pc_type PC_CLEAR   = 4'd6;
   localparam pc_type PC_DSHIFT  = 4'd11;
   localparam pc_type PC_CSHIFT  = 4'd12;
   localparam pc_type PC_PATTERN = 4'd13;

   function automatic ucode_type uc(logic rs, sel_type sel, logic wb30, logic wa2,
                                    logic rep, logic ld_cols, logic fin);
      ucode_type w;
      w.rs      = rs;
      w.sel     = sel;
      w.wb30    = wb30;
      w.wa2     = wa2;
      w.rep     = rep;
      w.ld_cols = ld_cols;
      w.fin     = fin;
      return w;
   endfunction

   function automatic ucode_type ucode_rom(pc_type pc);
      ucode_type w;
      case (pc)
         4'd0:  w = uc(1'b0, SEL_FSET,    1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
         4'd1:  w = uc(1'b0, SEL_DISP_ON, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
         4'd2:  w = uc(1'b0, SEL_CLEAR,   1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
         4'd3:  w = uc(1'b0, SEL_ENTRY,   1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
         4'd4:  w = uc(1'b1, SEL_CHAR,    1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
         4'd5:  w = uc(1'b0, SEL_CURSOR,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
         4'd6:  w = uc(1'b0, SEL_HOME,    1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
         4'd7:  w = uc(1'b1, SEL_SPACE,   1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
         4'd8:  w = uc(1'b0, SEL_LINE2,   1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
         4'd9:  w = uc(1'b1, SEL_SPACE,   1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
         4'd10: w = uc(1'b0, SEL_HOME,    1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
         4'd11: w = uc(1'b0, SEL_DSHIFT,  1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
         4'd12: w = uc(1'b0, SEL_CSHIFT,  1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
         4'd13: w = uc(1'b0, SEL_CGRAM,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
         4'd14: w = uc(1'b1, SEL_ROW,     1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
         4'd15: w = uc(1'b0, SEL_HOME,    1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
         default: w = uc(1'b0, SEL_HOME,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
      endcase
      return w;
   endfunction

endpackage

@@ design/clcd_datapath.sv @@
// Operand registers, bus byte selection and the result register.
// Depends on clcd_pkg.
module clcd_datapath import clcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  logic [7:0]  req_char_code,
   input  logic [1:0]  req_line,
   input  logic [5:0]  req_column,
   input  logic        req_direction,
   input  logic [2:0]  req_slot,
   input  logic [63:0] req_pattern_bits,
   input  cfg_type     cfg,
   input  issue_type   issue,
   output logic        out_free,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_register_select,
   output logic [7:0]  rsp_bus_byte,
   output logic [4:0]  rsp_wait_before_ms,
   output logic [1:0]  rsp_wait_after_ms,
   output logic        rsp_last
);

   logic [7:0]  char_ff, char_in;
   logic [7:0]  cursor_ff, cursor_in;
   logic        dir_ff, dir_in;
   logic [7:0]  cgram_ff, cgram_in;
   logic [63:0] pat_ff, pat_in;
   logic        valid_ff, valid_in;
   logic        rs_ff, rs_in;
   logic [7:0]  byte_ff, byte_in;
   logic [4:0]  wb_ff, wb_in;
   logic [1:0]  wa_ff, wa_in;
   logic        last_ff, last_in;
   logic [7:0]  sel_byte;
   logic [7:0]  cursor_addr;

   always_comb begin
      case (req_line)
         2'd1:    cursor_addr = {2'b00, req_column};
         2'd2:    cursor_addr = {2'b00, req_column} | LINE2_BASE;
         default: cursor_addr = 8'h00;
      endcase

      case (issue.uc.sel)
         SEL_FSET:    sel_byte = CMD_FUNCTION_SET |
                                 {3'b000, cfg.bus_8bit, cfg.two_lines, cfg.font, 2'b00};
         SEL_DISP_ON: sel_byte = CMD_DISPLAY_ON;
         SEL_CLEAR:   sel_byte = CMD_CLEAR;
         SEL_ENTRY:   sel_byte = CMD_ENTRY_MODE | {6'b000000, cfg.increment, 1'b0};
         SEL_HOME:    sel_byte = CMD_DDRAM;
         SEL_LINE2:   sel_byte = CMD_DDRAM | LINE2_BASE;
         SEL_SPACE:   sel_byte = CHAR_SPACE;
         SEL_CHAR:    sel_byte = char_ff;
         SEL_CURSOR:  sel_byte = cursor_ff;
         SEL_DSHIFT:  sel_byte = CMD_DISPLAY_SHIFT | {5'b00000, dir_ff, 2'b00};
         SEL_CSHIFT:  sel_byte = CMD_CURSOR_SHIFT | {5'b00000, dir_ff, 2'b00};
         SEL_CGRAM:   sel_byte = cgram_ff;
         SEL_ROW:     sel_byte = pat_ff[7:0];
         default:     sel_byte = CMD_DDRAM;
      endcase

      char_in   = char_ff;
      cursor_in = cursor_ff;
      dir_in    = dir_ff;
      cgram_in  = cgram_ff;
      pat_in    = pat_ff;
      if (load) begin
         char_in   = req_char_code;
         cursor_in = CMD_DDRAM | cursor_addr;
         dir_in    = req_direction;
         cgram_in  = CMD_CGRAM + {2'b00, req_slot, 3'b000};
         pat_in    = req_pattern_bits;
      end else if (issue.fire && issue.uc.sel == SEL_ROW) begin
         // next pattern row moves into the low byte
         pat_in = {8'h00, pat_ff[63:8]};
      end

      out_free = !valid_ff || !rsp_stall;
      valid_in = out_free ? issue.fire : valid_ff;
      rs_in    = rs_ff;
      byte_in  = byte_ff;
      wb_in    = wb_ff;
      wa_in    = wa_ff;
      last_in  = last_ff;
      if (issue.fire) begin
         rs_in   = issue.uc.rs;
         byte_in = sel_byte;
         wb_in   = issue.uc.wb30 ? WAIT_INIT_MS : 5'd0;
         wa_in   = (issue.uc.wa2 && issue.final_iter) ? WAIT_CMD_MS : 2'd0;
         last_in = issue.uc.fin && issue.final_iter;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      char_ff   <= char_in;
      cursor_ff <= cursor_in;
      dir_ff    <= dir_in;
      cgram_ff  <= cgram_in;
      pat_ff    <= pat_in;
      rs_ff     <= rs_in;
      byte_ff   <= byte_in;
      wb_ff     <= wb_in;
      wa_ff     <= wa_in;
      last_ff   <= last_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_register_select = rs_ff;
   assign rsp_bus_byte        = byte_ff;
   assign rsp_wait_before_ms  = wb_ff;
   assign rsp_wait_after_ms   = wa_ff;
   assign rsp_last            = last_ff;

endmodule

@@ design/clcd_sequencer.sv @@
// Microcode sequencer: request dispatch, step counter and loop counter.
// Depends on clcd_pkg (microcode ROM, entry points).
module clcd_sequencer import clcd_pkg::*; #(
   parameter int LINE_COLUMNS = DefLineColumns,
   parameter int MAX_SHIFT    = DefMaxShift
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  logic [2:0] req_kind,
   input  logic [7:0] req_count,
   input  logic      out_free,
   output logic      req_stall,
   output logic      accept,
   output issue_type issue
);

   localparam int ClearCap  = (MaxResults - 3) / 2;
   localparam int ClearCols = (LINE_COLUMNS > ClearCap) ? ClearCap : LINE_COLUMNS;
   localparam int ShiftCap  = (MAX_SHIFT < MaxResults) ? MAX_SHIFT : MaxResults;

   logic      busy_ff, busy_in;
   pc_type    pc_ff, pc_in;
   cnt_type   cnt_ff, cnt_in;
   pc_type    start_pc;
   cnt_type   start_cnt;
   logic      start_busy;
   logic [7:0] count_sat;
   ucode_type uc_word;
   logic      final_iter;
   logic      fire;

   always_comb begin
      accept    = req_valid && !busy_ff;
      count_sat = (req_count > 8'(ShiftCap)) ? 8'(ShiftCap) : req_count;

      start_pc   = PC_INIT;
      start_cnt  = cnt_type'(PatternRows);
      start_busy = 1'b1;
      case (req_kind)
         KIND_INIT:    start_pc = PC_INIT;
         KIND_CHAR:    start_pc = PC_CHAR;
         KIND_CURSOR:  start_pc = PC_CURSOR;
         KIND_CLEAR:   start_pc = PC_CLEAR;
         KIND_DSHIFT, KIND_CSHIFT: begin
            start_pc   = (req_kind == KIND_DSHIFT) ? PC_DSHIFT : PC_CSHIFT;
            start_cnt  = cnt_type'(count_sat);
            // a zero count gives no writes at all
            start_busy = (count_sat != 8'd0);
         end
         KIND_PATTERN: start_pc = PC_PATTERN;
         default:      start_busy = 1'b0;
      endcase

      uc_word    = ucode_rom(pc_ff);
      final_iter = !uc_word.rep || (cnt_ff == cnt_type'(1));
      fire       = busy_ff && out_free;

      busy_in = busy_ff;
      pc_in   = pc_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         busy_in = start_busy;
         pc_in   = start_pc;
         cnt_in  = start_cnt;
      end else if (fire) begin
         if (!final_iter) begin
            cnt_in = cnt_ff - cnt_type'(1);
         end else begin
            pc_in = pc_ff + pc_type'(1);
            if (uc_word.fin) begin
               busy_in = 1'b0;
            end
         end
         if (uc_word.ld_cols) begin
            cnt_in = cnt_type'(ClearCols);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= PC_INIT;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign req_stall        = busy_ff;
   assign issue.fire       = fire;
   assign issue.uc         = uc_word;
   assign issue.final_iter = final_iter;

endmodule

@@ design/char_lcd_command_sequencer.sv @@
// Character-LCD command sequencer, top level; uses clcd_pkg, clcd_sequencer and
// clcd_datapath. Each accepted request becomes a run of 8-bit bus writes, one per
// cycle from a 16-step microcode ROM while the result side does not stall: init
// gives 4 writes, write char and set cursor 1, clear 2*min(LINE_COLUMNS,18)+3,
// shifts min(count,MAX_SHIFT,40) (a zero count or kind 7 gives none), pattern 10.
// An item holds the block until its run is issued; the next request is taken once
// the final write has gone into the result register. Configuration bits are read
// while the run is issued; the user must write them while idle (not enforced).
module char_lcd_command_sequencer import clcd_pkg::*; #(
   parameter int LINE_COLUMNS = DefLineColumns,
   parameter int MAX_SHIFT    = DefMaxShift
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_char_code,
   input  logic [1:0]  req_line,
   input  logic [5:0]  req_column,
   input  logic        req_direction,
   input  logic [7:0]  req_count,
   input  logic [2:0]  req_slot,
   input  logic [63:0] req_pattern_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_register_select,
   output logic [7:0]  rsp_bus_byte,
   output logic [4:0]  rsp_wait_before_ms,
   output logic [1:0]  rsp_wait_after_ms,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic        csr_write_data
);

   cfg_type   cfg_ff, cfg_in;
   issue_type issue;
   logic      accept;
   logic      out_free;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FONT:      cfg_in.font      = csr_write_data;
            CSR_TWO_LINES: cfg_in.two_lines = csr_write_data;
            CSR_BUS_8BIT:  cfg_in.bus_8bit  = csr_write_data;
            CSR_INCREMENT: cfg_in.increment = csr_write_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.font      <= 1'b0;
         cfg_ff.two_lines <= 1'b1;
         cfg_ff.bus_8bit  <= 1'b1;
         cfg_ff.increment <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   clcd_sequencer #(
      .LINE_COLUMNS (LINE_COLUMNS),
      .MAX_SHIFT    (MAX_SHIFT)
   ) u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_count (req_count),
      .out_free  (out_free),
      .req_stall (req_stall),
      .accept    (accept),
      .issue     (issue)
   );

   clcd_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .load                (accept),
      .req_char_code       (req_char_code),
      .req_line            (req_line),
      .req_column          (req_column),
      .req_direction       (req_direction),
      .req_slot            (req_slot),
      .req_pattern_bits    (req_pattern_bits),
      .cfg                 (cfg_ff),
      .issue               (issue),
      .out_free            (out_free),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_register_select (rsp_register_select),
      .rsp_bus_byte        (rsp_bus_byte),
      .rsp_wait_before_ms  (rsp_wait_before_ms),
      .rsp_wait_after_ms   (rsp_wait_after_ms),
      .rsp_last            (rsp_last)
   );

endmodule

@@ design/clcd_checker.sv @@
// Port-level checker for the LCD command sequencer, bound to the top level.
// Depends on clcd_pkg and char_lcd_command_sequencer_assert.svh.
`include "char_lcd_command_sequencer_assert.svh"

module clcd_checker import clcd_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [2:0] req_kind,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_register_select,
   input logic [7:0] rsp_bus_byte,
   input logic [4:0] rsp_wait_before_ms,
   input logic [1:0] rsp_wait_after_ms,
   input logic       rsp_last
);

   `CLCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_bus_byte) && $stable(rsp_last))

   // init always produces writes, so the block must be busy right after it
   `CLCD_ASSERT_NEXT(a_init_busy, clock, reset,
                     req_valid && !req_stall && req_kind == KIND_INIT, req_stall)

   `CLCD_ASSERT_NOW(a_data_no_wait, clock, reset, rsp_valid && rsp_register_select,
                    rsp_wait_before_ms == 5'd0 && rsp_wait_after_ms == 2'd0)

   // only the first init write carries the power-up wait
   `CLCD_ASSERT_NOW(a_init_wait, clock, reset, rsp_valid && rsp_wait_before_ms != 5'd0,
                    rsp_wait_before_ms == WAIT_INIT_MS && !rsp_register_select && !rsp_last)

endmodule

bind char_lcd_command_sequencer clcd_checker u_clcd_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_kind            (req_kind),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_register_select (rsp_register_select),
   .rsp_bus_byte        (rsp_bus_byte),
   .rsp_wait_before_ms  (rsp_wait_before_ms),
   .rsp_wait_after_ms   (rsp_wait_after_ms),
   .rsp_last            (rsp_last)
);

@@ sim/tb_char_lcd_command_sequencer.sv @@
// Testbench for char_lcd_command_sequencer: a directed and random request stream is
// expanded into bus writes by a local predictor and checked write by write.
// Depends on clcd_pkg and the char_lcd_command_sequencer RTL.
module tb_char_lcd_command_sequencer;
   import clcd_pkg::*;

   localparam int DRAIN_CYCLES = 60;
   localparam int CLEAR_COLS   = (DefLineColumns > (MaxResults - 3) / 2) ?
                                 (MaxResults - 3) / 2 : DefLineColumns;
   localparam logic [2:0] KIND_UNUSED = 3'd7;

   typedef struct {
      logic [2:0]  kind;
      logic [7:0]  char_code;
      logic [1:0]  line;
      logic [5:0]  column;
      logic        direction;
      logic [7:0]  count;
      logic [2:0]  slot;
      logic [63:0] pattern_bits;
   } lcd_req_type;

   typedef struct {
      logic       register_select;
      logic [7:0] bus_byte;
      logic [4:0] wait_before_ms;
      logic [1:0] wait_after_ms;
      logic       last;
   } bus_write_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind = '0;
   logic [7:0]  req_char_code = '0;
   logic [1:0]  req_line = '0;
   logic [5:0]  req_column = '0;
   logic        req_direction = 1'b0;
   logic [7:0]  req_count = '0;
   logic [2:0]  req_slot = '0;
   logic [63:0] req_pattern_bits = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_register_select;
   logic [7:0]  rsp_bus_byte;
   logic [4:0]  rsp_wait_before_ms;
   logic [1:0]  rsp_wait_after_ms;
   logic        rsp_last;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic        csr_write_data = 1'b0;

   lcd_req_type   pending_reqs[$];
   bus_write_type expected_writes[$];
   lcd_req_type   cur_req;
   cfg_type       lcd_cfg;
   bit            quiet = 1'b0;
   int            mismatches = 0;

   char_lcd_command_sequencer dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_char_code       (req_char_code),
      .req_line            (req_line),
      .req_column          (req_column),
      .req_direction       (req_direction),
      .req_count           (req_count),
      .req_slot            (req_slot),
      .req_pattern_bits    (req_pattern_bits),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_register_select (rsp_register_select),
      .rsp_bus_byte        (rsp_bus_byte),
      .rsp_wait_before_ms  (rsp_wait_before_ms),
      .rsp_wait_after_ms   (rsp_wait_after_ms),
      .rsp_last            (rsp_last),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always #4 clock = ~clock;

   function automatic bit idle_roll();
      return !quiet && ($urandom_range(0, 99) < 36);
   endfunction

   function automatic bus_write_type mk_write(logic rs, logic [7:0] b, logic [4:0] wb,
                                              logic [1:0] wa);
      bus_write_type w;
      w.register_select = rs;
      w.bus_byte        = b;
      w.wait_before_ms  = wb;
      w.wait_after_ms   = wa;
      w.last            = 1'b0;
      return w;
   endfunction

   // lines other than 1 and 2 land on address 0
   function automatic logic [7:0] ddram_cmd(logic [1:0] line, logic [5:0] column);
      logic [7:0] addr;
      addr = 8'h00;
      if (line == 2'd1)
         addr = {2'b00, column};
      else if (line == 2'd2)
         addr = {2'b00, column} | LINE2_BASE;
      return CMD_DDRAM | addr;
   endfunction

   function automatic void expand_request(lcd_req_type r);
      bus_write_type run[$];
      int            steps;
      logic [7:0]    base;
      case (r.kind)
         KIND_INIT: begin
            run.push_back(mk_write(1'b0, CMD_FUNCTION_SET | {3'b000, lcd_cfg.bus_8bit,
                          lcd_cfg.two_lines, lcd_cfg.font, 2'b00}, WAIT_INIT_MS,
                          WAIT_CMD_MS));
            run.push_back(mk_write(1'b0, CMD_DISPLAY_ON, 5'd0, WAIT_CMD_MS));
            run.push_back(mk_write(1'b0, CMD_CLEAR, 5'd0, WAIT_CMD_MS));
            run.push_back(mk_write(1'b0, CMD_ENTRY_MODE | {6'b0, lcd_cfg.increment, 1'b0},
                          5'd0, WAIT_CMD_MS));
         end
         KIND_CHAR:
            run.push_back(mk_write(1'b1, r.char_code, 5'd0, 2'd0));
         KIND_CURSOR:
            run.push_back(mk_write(1'b0, ddram_cmd(r.line, r.column), 5'd0, 2'd0));
         KIND_CLEAR: begin
            run.push_back(mk_write(1'b0, ddram_cmd(2'd1, 6'd0), 5'd0, 2'd0));
            repeat (CLEAR_COLS) run.push_back(mk_write(1'b1, CHAR_SPACE, 5'd0, 2'd0));
            run.push_back(mk_write(1'b0, ddram_cmd(2'd2, 6'd0), 5'd0, 2'd0));
            repeat (CLEAR_COLS) run.push_back(mk_write(1'b1, CHAR_SPACE, 5'd0, 2'd0));
            run.push_back(mk_write(1'b0, ddram_cmd(2'd1, 6'd0), 5'd0, 2'd0));
         end
         KIND_DSHIFT, KIND_CSHIFT: begin
            base  = (r.kind == KIND_DSHIFT) ? CMD_DISPLAY_SHIFT : CMD_CURSOR_SHIFT;
            steps = int'(r.count);
            if (steps > DefMaxShift) steps = DefMaxShift;
            if (steps > MaxResults) steps = MaxResults;
            for (int i = 0; i < steps; i++)
               run.push_back(mk_write(1'b0, base | {5'b0, r.direction, 2'b00}, 5'd0,
                             (i == steps - 1) ? WAIT_CMD_MS : 2'd0));
         end
         KIND_PATTERN: begin
            run.push_back(mk_write(1'b0, CMD_CGRAM + {2'b00, r.slot, 3'b000}, 5'd0, 2'd0));
            for (int i = 0; i < PatternRows; i++)
               run.push_back(mk_write(1'b1, r.pattern_bits[8*i +: 8], 5'd0, 2'd0));
            run.push_back(mk_write(1'b0, CMD_DDRAM, 5'd0, WAIT_CMD_MS));
         end
         default: ;
      endcase
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[i]) expected_writes.push_back(run[i]);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expand_request(cur_req);
         if (!(req_valid && req_stall)) begin
            if (pending_reqs.size() > 0 && !idle_roll()) begin
               cur_req = pending_reqs.pop_front();
               req_kind         <= cur_req.kind;
               req_char_code    <= cur_req.char_code;
               req_line         <= cur_req.line;
               req_column       <= cur_req.column;
               req_direction    <= cur_req.direction;
               req_count        <= cur_req.count;
               req_slot         <= cur_req.slot;
               req_pattern_bits <= cur_req.pattern_bits;
               req_valid        <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         mismatches++;
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      bus_write_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_writes.size() == 0) begin
            $error("unexpected bus write: rs %0b byte %0h", rsp_register_select,
                   rsp_bus_byte);
            mismatches++;
         end else begin
            w = expected_writes.pop_front();
            check_field("register_select", 8'(w.register_select),
                        8'(rsp_register_select));
            check_field("bus_byte", w.bus_byte, rsp_bus_byte);
            check_field("wait_before_ms", 8'(w.wait_before_ms), 8'(rsp_wait_before_ms));
            check_field("wait_after_ms", 8'(w.wait_after_ms), 8'(rsp_wait_after_ms));
            check_field("last", 8'(w.last), 8'(rsp_last));
         end
      end
      rsp_stall <= reset ? 1'b0 : idle_roll();
   end

   task automatic push_req(logic [2:0] kind, logic [7:0] ch, logic [1:0] line,
                           logic [5:0] col, logic dir, logic [7:0] cnt, logic [2:0] slot,
                           logic [63:0] pat);
      lcd_req_type r;
      r.kind = kind; r.char_code = ch; r.line = line; r.column = col;
      r.direction = dir; r.count = cnt; r.slot = slot; r.pattern_bits = pat;
      pending_reqs.push_back(r);
   endtask

   // mostly well-formed kinds, small shift counts, occasional unused kind
   task automatic add_random(int n);
      int         made;
      logic [2:0] kind;
      logic [7:0] cnt;
      int         roll;
      made = 0;
      push_req(KIND_INIT, 8'($urandom), 2'($urandom), 6'($urandom), 1'($urandom),
               8'($urandom), 3'($urandom), {$urandom, $urandom});
      while (made < n) begin
         kind = ($urandom_range(0, 99) < 4) ? KIND_UNUSED : 3'($urandom_range(0, 6));
         roll = $urandom_range(0, 99);
         if (roll < 60)      cnt = 8'($urandom_range(0, 6));
         else if (roll < 85) cnt = 8'($urandom_range(7, 45));
         else                cnt = 8'($urandom_range(0, 255));
         push_req(kind, 8'($urandom), 2'($urandom), 6'($urandom), 1'($urandom), cnt,
                  3'($urandom), {$urandom, $urandom});
         if (kind <= KIND_PATTERN &&
             !((kind == KIND_DSHIFT || kind == KIND_CSHIFT) && cnt == 0))
            made++;
      end
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_reqs.size() > 0 || req_valid || expected_writes.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_FONT:      lcd_cfg.font      = val;
         CSR_TWO_LINES: lcd_cfg.two_lines = val;
         CSR_BUS_8BIT:  lcd_cfg.bus_8bit  = val;
         CSR_INCREMENT: lcd_cfg.increment = val;
         default: ;
      endcase
   endtask

   initial begin
      cfg_type c;
      lcd_cfg.font      = 1'b0;
      lcd_cfg.two_lines = 1'b1;
      lcd_cfg.bus_8bit  = 1'b1;
      lcd_cfg.increment = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset configuration
      push_req(KIND_INIT,    8'h00, 2'd0, 6'd0,  1'b0, 8'd0,   3'd0, 64'h0);
      push_req(KIND_CHAR,    8'h00, 2'd0, 6'd0,  1'b0, 8'd0,   3'd0, 64'h0);
      push_req(KIND_CHAR,    8'hFF, 2'd0, 6'd0,  1'b0, 8'd0,   3'd0, 64'h0);
      push_req(KIND_CURSOR,  8'h00, 2'd0, 6'd63, 1'b0, 8'd0,   3'd0, 64'h0);
      push_req(KIND_CURSOR,  8'h00, 2'd1, 6'd0,  1'b0, 8'd0,   3'd0, 64'h0);
      push_req(KIND_CURSOR,  8'h00, 2'd1, 6'd63, 1'b0, 8'd0,   3'd0, 64'h0);
      push_req(KIND_CURSOR,  8'h00, 2'd2, 6'd0,  1'b0, 8'd0,   3'd0, 64'h0);
      push_req(KIND_CURSOR,  8'h00, 2'd2, 6'd63, 1'b0, 8'd0,   3'd0, 64'h0);
      push_req(KIND_CURSOR,  8'h00, 2'd3, 6'd21, 1'b0, 8'd0,   3'd0, 64'h0);
      push_req(KIND_CLEAR,   8'h00, 2'd0, 6'd0,  1'b0, 8'd0,   3'd0, 64'h0);
      push_req(KIND_DSHIFT,  8'h00, 2'd0, 6'd0,  1'b0, 8'd0,   3'd0, 64'h0);
      push_req(KIND_DSHIFT,  8'h00, 2'd0, 6'd0,  1'b1, 8'd1,   3'd0, 64'h0);
      push_req(KIND_DSHIFT,  8'h00, 2'd0, 6'd0,  1'b0, 8'd40,  3'd0, 64'h0);
      push_req(KIND_DSHIFT,  8'h00, 2'd0, 6'd0,  1'b1, 8'd41,  3'd0, 64'h0);
      push_req(KIND_DSHIFT,  8'h00, 2'd0, 6'd0,  1'b0, 8'd255, 3'd0, 64'h0);
      push_req(KIND_CSHIFT,  8'h00, 2'd0, 6'd0,  1'b1, 8'd0,   3'd0, 64'h0);
      push_req(KIND_CSHIFT,  8'h00, 2'd0, 6'd0,  1'b0, 8'd1,   3'd0, 64'h0);
      push_req(KIND_CSHIFT,  8'h00, 2'd0, 6'd0,  1'b1, 8'd40,  3'd0, 64'h0);
      push_req(KIND_CSHIFT,  8'h00, 2'd0, 6'd0,  1'b0, 8'd200, 3'd0, 64'h0);
      push_req(KIND_PATTERN, 8'h00, 2'd0, 6'd0,  1'b0, 8'd0,   3'd0, 64'h0);
      push_req(KIND_PATTERN, 8'h00, 2'd0, 6'd0,  1'b0, 8'd0,   3'd7, '1);
      push_req(KIND_PATTERN, 8'h00, 2'd0, 6'd0,  1'b0, 8'd0,   3'd3,
               64'h0123_4567_89AB_CDEF);
      push_req(KIND_UNUSED,  8'h00, 2'd0, 6'd0,  1'b0, 8'd0,   3'd0, 64'h0);
      add_random(12);
      drain();

      // all-zero, all-one, then random settings; one phase runs without idling
      for (int p = 1; p <= 5; p++) begin
         if (p == 1)      c = '0;
         else if (p == 2) c = '1;
         else             c = 4'($urandom_range(0, 15));
         quiet = (p == 2);
         write_reg(CSR_FONT,      c.font);
         write_reg(CSR_TWO_LINES, c.two_lines);
         write_reg(CSR_BUS_8BIT,  c.bus_8bit);
         write_reg(CSR_INCREMENT, c.increment);
         add_random(13);
         drain();
         quiet = 1'b0;
      end

      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
